// File: src/single_slot_credential_lease_macros.svh
// Assertion macros for the single-slot credential lease checker.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef SINGLE_SLOT_CREDENTIAL_LEASE_MACROS_SVH
`define SINGLE_SLOT_CREDENTIAL_LEASE_MACROS_SVH

// A property checked on every rising edge outside reset.
`define SSCL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lease checker: property violated");

// A property checked on every rising edge, reset included.
`define SSCL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lease checker: property violated during reset");

`endif

// File: src/sscl_pkg.sv
// Shared types, constants and helper functions for the credential lease block.
// Used by the decision logic, the top level and the checker; no dependencies.
`default_nettype none

package sscl_pkg;

  localparam int TAG_BITS      = 64;
  localparam int TIME_BITS     = 40;
  localparam int LEN_BITS      = 9;
  localparam int TTL_BITS      = 16;
  localparam int MODE_BITS     = 3;
  localparam int MAX_FIELD_LEN = 256;

  localparam logic [TTL_BITS-1:0] MAX_TTL_RESET = TTL_BITS'(30000);

  localparam logic [MODE_BITS-1:0] MODE_ACQUIRE = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_CONSUME = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_RELEASE = MODE_BITS'(2);
  localparam logic [MODE_BITS-1:0] MODE_ABANDON = MODE_BITS'(3);

  typedef enum logic [2:0] {
    PH_ABANDONED = 3'd0,
    PH_ACTIVE    = 3'd1,
    PH_EXPIRED   = 3'd2,
    PH_CONSUMED  = 3'd3,
    PH_RELEASED  = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    RC_OK         = 4'd0,
    RC_ALREADY    = 4'd1,
    RC_INVALID    = 4'd2,
    RC_EXPIRED    = 4'd3,
    RC_NOT_ACTIVE = 4'd4,
    RC_HANDLE     = 4'd5,
    RC_PURPOSE    = 4'd6,
    RC_GENERATION = 4'd7,
    RC_NONCE      = 4'd8,
    RC_CONSUMER   = 4'd9
  } rc_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [TIME_BITS-1:0] now;
    logic [TAG_BITS-1:0]  handle_tag;
    logic [LEN_BITS-1:0]  handle_len;
    logic [TAG_BITS-1:0]  purpose_tag;
    logic [LEN_BITS-1:0]  purpose_len;
    logic [TAG_BITS-1:0]  generation_tag;
    logic [LEN_BITS-1:0]  generation_len;
    logic [TAG_BITS-1:0]  nonce_tag;
    logic [LEN_BITS-1:0]  nonce_len;
    logic [TTL_BITS-1:0]  ttl;
    logic                 consumer_ok;
  } item_t;

  typedef struct packed {
    logic                 has_record;
    phase_t               phase;
    logic [TAG_BITS-1:0]  handle;
    logic [LEN_BITS-1:0]  handle_len;
    logic [TAG_BITS-1:0]  purpose;
    logic [LEN_BITS-1:0]  purpose_len;
    logic [TAG_BITS-1:0]  generation;
    logic [LEN_BITS-1:0]  generation_len;
    logic [TAG_BITS-1:0]  nonce;
    logic [LEN_BITS-1:0]  nonce_len;
    logic [TIME_BITS-1:0] expiry;
  } rec_t;

  localparam rec_t REC_RESET = '0;

  function automatic logic len_ok(input logic [LEN_BITS-1:0] len);
    return (len != '0) && (len <= LEN_BITS'(MAX_FIELD_LEN));
  endfunction

  function automatic logic same(input logic [TAG_BITS-1:0] ta,
                                input logic [LEN_BITS-1:0] la,
                                input logic [TAG_BITS-1:0] tb,
                                input logic [LEN_BITS-1:0] lb);
    return (ta == tb) && (la == lb);
  endfunction

endpackage

`default_nettype wire

// File: src/sscl_engine.sv
// Decision logic for one command against the lease record: expiry, checks,
// result code and the next record. Depends on sscl_pkg.
`default_nettype none

module sscl_engine
  import sscl_pkg::*;
(
  input  item_t               item,
  input  rec_t                rec,
  input  logic [TTL_BITS-1:0] max_ttl,
  output rec_t                rec_next,
  output rc_t                 code,
  output phase_t              status
);

  logic                 active_pre;
  logic                 expire;
  logic                 active;
  logic                 acquire_ok;
  logic                 force_none;
  logic [TIME_BITS:0]   expiry_sum;
  logic [TIME_BITS-1:0] expiry_sat;

  assign active_pre = rec.has_record && (rec.phase == PH_ACTIVE);
  assign expire     = active_pre && (item.now >= rec.expiry);
  assign active     = active_pre && !expire;

  assign acquire_ok = len_ok(item.handle_len) && len_ok(item.purpose_len) &&
                      len_ok(item.generation_len) && len_ok(item.nonce_len) &&
                      (item.ttl != '0) && (item.ttl <= max_ttl);

  assign expiry_sum = {1'b0, item.now} + (TIME_BITS+1)'(item.ttl);
  assign expiry_sat = expiry_sum[TIME_BITS] ? '1 : expiry_sum[TIME_BITS-1:0];

  always_comb begin
    rec_next   = rec;
    code       = RC_OK;
    force_none = 1'b0;
    if (expire) begin
      rec_next.phase     = PH_EXPIRED;
      rec_next.nonce     = '0;
      rec_next.nonce_len = '0;
    end
    unique case (item.mode)
      MODE_ACQUIRE: begin
        if (active) begin
          code = RC_ALREADY;
        end else if (!acquire_ok) begin
          code       = RC_INVALID;
          force_none = 1'b1;
        end else begin
          rec_next.has_record     = 1'b1;
          rec_next.phase          = PH_ACTIVE;
          rec_next.handle         = item.handle_tag;
          rec_next.handle_len     = item.handle_len;
          rec_next.purpose        = item.purpose_tag;
          rec_next.purpose_len    = item.purpose_len;
          rec_next.generation     = item.generation_tag;
          rec_next.generation_len = item.generation_len;
          rec_next.nonce          = item.nonce_tag;
          rec_next.nonce_len      = item.nonce_len;
          rec_next.expiry         = expiry_sat;
        end
      end
      MODE_CONSUME: begin
        if (!active) begin
          code = (rec_next.has_record && rec_next.phase == PH_EXPIRED) ?
                 RC_EXPIRED : RC_NOT_ACTIVE;
        end else if (!same(rec.handle, rec.handle_len,
                           item.handle_tag, item.handle_len)) begin
          code = RC_HANDLE;
        end else if (!same(rec.purpose, rec.purpose_len,
                           item.purpose_tag, item.purpose_len)) begin
          code = RC_PURPOSE;
        end else if (!same(rec.generation, rec.generation_len,
                           item.generation_tag, item.generation_len)) begin
          code = RC_GENERATION;
        end else if (!len_ok(item.nonce_len)) begin
          code = RC_INVALID;
        end else if (!same(rec.nonce, rec.nonce_len,
                           item.nonce_tag, item.nonce_len)) begin
          code = RC_NONCE;
        end else begin
          rec_next.phase     = PH_CONSUMED;
          rec_next.nonce     = '0;
          rec_next.nonce_len = '0;
          code = item.consumer_ok ? RC_OK : RC_CONSUMER;
        end
      end
      MODE_RELEASE: begin
        if (!active) begin
          code = RC_NOT_ACTIVE;
        end else if (!same(rec.handle, rec.handle_len,
                           item.handle_tag, item.handle_len)) begin
          code = RC_HANDLE;
        end else begin
          rec_next.phase     = PH_RELEASED;
          rec_next.nonce     = '0;
          rec_next.nonce_len = '0;
        end
      end
      MODE_ABANDON: begin
        if (!active) begin
          code = RC_NOT_ACTIVE;
        end else if (!same(rec.generation, rec.generation_len,
                           item.generation_tag, item.generation_len)) begin
          code = RC_GENERATION;
        end else begin
          rec_next.phase     = PH_ABANDONED;
          rec_next.nonce     = '0;
          rec_next.nonce_len = '0;
        end
      end
      default: begin
        code = RC_OK;
      end
    endcase
    if (force_none || !rec_next.has_record) begin
      status = PH_ABANDONED;
    end else begin
      status = rec_next.phase;
    end
  end

endmodule

`default_nettype wire

// File: src/single_slot_credential_lease.sv
// Top level of the single-slot credential lease: channel handshakes, the
// command register, the lease record and the result register.
// Depends on sscl_pkg and sscl_engine.
//
// Commands arrive on the input channel (in_valid, in_stall) and one result
// transaction leaves on the output channel (out_valid, out_stall) for each.
// A transaction moves at a rising edge where valid is high and stall is low.
// A command is captured in an input register and decided against the lease
// record; its code and lease_status are registered when it advances, which a
// stalled output holds off. One command is accepted every cycle while the
// output is not stalled; the record is updated as each command is decided, so
// consecutive commands see each other's effects in order. When the receiver
// stalls, the result holds and the input register keeps accepting until it
// fills, after which in_stall rises. max_ttl is written through cfg_we and
// cfg_wdata; the user must do so only while the block is idle, as the block
// does not enforce it. Synchronous reset empties both registers, clears the
// record to no lease and sets max_ttl to 30000; no clearing pass is needed.
`default_nettype none

module single_slot_credential_lease
  import sscl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [MODE_BITS-1:0] mode,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [TAG_BITS-1:0]  handle_tag,
  input  wire logic [LEN_BITS-1:0]  handle_len,
  input  wire logic [TAG_BITS-1:0]  purpose_tag,
  input  wire logic [LEN_BITS-1:0]  purpose_len,
  input  wire logic [TAG_BITS-1:0]  generation_tag,
  input  wire logic [LEN_BITS-1:0]  generation_len,
  input  wire logic [TAG_BITS-1:0]  nonce_tag,
  input  wire logic [LEN_BITS-1:0]  nonce_len,
  input  wire logic [TTL_BITS-1:0]  ttl,
  input  wire logic                 consumer_ok,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [3:0]           code,
  output      logic [2:0]           lease_status,
  input  wire logic                 cfg_we,
  input  wire logic [TTL_BITS-1:0]  cfg_wdata
);

  logic                item_valid;
  item_t               item;
  rec_t                rec;
  rec_t                rec_next;
  logic [TTL_BITS-1:0] max_ttl;
  rc_t                 code_q;
  phase_t              status_q;
  rc_t                 code_next;
  phase_t              status_next;
  logic                advance;
  logic                accept;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  sscl_engine u_engine (
    .item     (item),
    .rec      (rec),
    .max_ttl  (max_ttl),
    .rec_next (rec_next),
    .code     (code_next),
    .status   (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      rec        <= REC_RESET;
      max_ttl    <= MAX_TTL_RESET;
    end else begin
      if (cfg_we) begin
        max_ttl <= cfg_wdata;
      end
      if (accept) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        rec       <= rec_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.mode           <= mode;
      item.now            <= now;
      item.handle_tag     <= handle_tag;
      item.handle_len     <= handle_len;
      item.purpose_tag    <= purpose_tag;
      item.purpose_len    <= purpose_len;
      item.generation_tag <= generation_tag;
      item.generation_len <= generation_len;
      item.nonce_tag      <= nonce_tag;
      item.nonce_len      <= nonce_len;
      item.ttl            <= ttl;
      item.consumer_ok    <= consumer_ok;
    end
    if (advance) begin
      code_q   <= code_next;
      status_q <= status_next;
    end
  end

  assign code         = code_q;
  assign lease_status = status_q;

endmodule

`default_nettype wire

// File: src/sscl_checker.sv
// Port-level checker for the credential lease block, bound to its top level.
// Depends on sscl_pkg and single_slot_credential_lease_macros.svh.
`default_nettype none

`include "single_slot_credential_lease_macros.svh"

module sscl_checker
  import sscl_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] code,
  input wire logic [2:0] lease_status
);

  `SSCL_ASSERT(a_out_held, out_valid && out_stall |=> out_valid)
  `SSCL_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(code) && $stable(lease_status))
  `SSCL_ASSERT(a_already_active, out_valid && (code == RC_ALREADY) |-> (lease_status == PH_ACTIVE))
  `SSCL_ASSERT(a_verdict_consumed, out_valid && (code == RC_CONSUMER) |-> (lease_status == PH_CONSUMED))
  `SSCL_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_stall)

endmodule

bind single_slot_credential_lease sscl_checker u_sscl_checker (.*);

`default_nettype wire
